// File: hdl/prl_pkg.sv
// shared types and constants for the priority ready list
package prl_pkg;

  localparam int MAX_TASKS  = 16;
  localparam int PRIO_BITS  = 8;
  localparam int ID_W       = 4;
  localparam int IN_PRIO_W  = 8;
  localparam int OUT_PRIO_W = 8;
  localparam int RANK_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int OP_W       = 2;
  localparam int ID_COUNT   = 2 ** ID_W;
  localparam int IDX_W      = $clog2(MAX_TASKS);
  localparam int CNT_W      = $clog2(MAX_TASKS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_LIST
  } state_t;

  typedef struct packed {
    logic    load;
    logic    idx_inc;
    logic    do_insert;
    logic    do_remove;
    logic    emit;
    status_t status;
  } prl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            present;
    logic            full;
    logic            empty;
    logic            scan_stop;
    logic            list_last;
  } prl_stat_t;

endpackage

// File: hdl/prl_ctrl.sv
// sequencer for insert, remove and list transactions
module prl_ctrl import prl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  prl_stat_t stat,
  output prl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.status    = ST_INSERTED;
    busy          = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        if (stat.op == OP_INSERT) begin
          if (!stat.present && stat.full) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_ABSENT;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (stat.op == OP_REMOVE) begin
          if (!stat.present) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_ABSENT;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (stat.op == OP_LIST) begin
          if (stat.empty) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_EMPTY;
          end else begin
            state_nxt = S_LIST;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_stop) begin
          state_nxt = S_IDLE;
          cmd.emit  = 1'b1;
          if (stat.op == OP_REMOVE) begin
            cmd.do_remove = 1'b1;
            cmd.status    = ST_REMOVED;
          end else if (stat.present) begin
            cmd.status = ST_PRESENT;
          end else begin
            cmd.do_insert = 1'b1;
            cmd.status    = ST_INSERTED;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_LIST: begin
        cmd.emit    = 1'b1;
        cmd.status  = ST_ENTRY;
        cmd.idx_inc = 1'b1;
        if (stat.list_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/prl_datapath.sv
// sorted task store, scan pointer and result registers
module prl_datapath import prl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [ID_W-1:0]       in_task_id,
  input  logic [IN_PRIO_W-1:0]  in_priority_req,
  input  prl_cmd_t              cmd,
  output prl_stat_t             stat,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ID_W-1:0]       out_task,
  output logic [OUT_PRIO_W-1:0] out_priority,
  output logic [RANK_W-1:0]     out_rank,
  output logic                  out_last
);

  logic [OP_W-1:0]      op_r;
  logic [ID_W-1:0]      id_r;
  logic [PRIO_BITS-1:0] prio_r;
  logic [CNT_W-1:0]     idx_r;
  logic [CNT_W-1:0]     count_r;
  logic [ID_COUNT-1:0]  present_r;
  logic [ID_W-1:0]      ids_r   [MAX_TASKS];
  logic [PRIO_BITS-1:0] prios_r [MAX_TASKS];

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [ID_W-1:0]       out_task_r;
  logic [OUT_PRIO_W-1:0] out_priority_r;
  logic [RANK_W-1:0]     out_rank_r;
  logic                  out_last_r;

  logic [ID_W-1:0]      rd_id;
  logic [PRIO_BITS-1:0] rd_prio;
  logic                 hit;

  assign rd_id   = ids_r[idx_r[IDX_W-1:0]];
  assign rd_prio = prios_r[idx_r[IDX_W-1:0]];
  assign hit     = present_r[id_r] ? (rd_id == id_r) : (rd_prio < prio_r);

  assign stat.op        = op_r;
  assign stat.present   = present_r[id_r];
  assign stat.full      = (count_r == CNT_W'(MAX_TASKS));
  assign stat.empty     = (count_r == '0);
  assign stat.scan_stop = (idx_r == count_r) || hit;
  assign stat.list_last = ((idx_r + CNT_W'(1)) == count_r);

  // transaction fields and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      id_r   <= in_task_id;
      prio_r <= PRIO_BITS'(in_priority_req);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      present_r <= '0;
    end else if (cmd.do_insert) begin
      count_r         <= count_r + CNT_W'(1);
      present_r[id_r] <= 1'b1;
    end else if (cmd.do_remove) begin
      count_r         <= count_r - CNT_W'(1);
      present_r[id_r] <= 1'b0;
    end
  end

  // cells from the scan index on move tailward on insert, headward on remove
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic [ID_W-1:0]      up_id;
    logic [PRIO_BITS-1:0] up_prio;
    logic [ID_W-1:0]      dn_id;
    logic [PRIO_BITS-1:0] dn_prio;

    if (i == 0) begin : g_head
      assign up_id   = id_r;
      assign up_prio = prio_r;
    end else begin : g_body
      assign up_id   = ids_r[i-1];
      assign up_prio = prios_r[i-1];
    end

    if (i == MAX_TASKS - 1) begin : g_tail
      assign dn_id   = ids_r[i];
      assign dn_prio = prios_r[i];
    end else begin : g_inner
      assign dn_id   = ids_r[i+1];
      assign dn_prio = prios_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.do_insert) begin
        if (CNT_W'(i) > idx_r) begin
          ids_r[i]   <= up_id;
          prios_r[i] <= up_prio;
        end else if (CNT_W'(i) == idx_r) begin
          ids_r[i]   <= id_r;
          prios_r[i] <= prio_r;
        end
      end else if (cmd.do_remove) begin
        if (CNT_W'(i) >= idx_r) begin
          ids_r[i]   <= dn_id;
          prios_r[i] <= dn_prio;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      unique case (cmd.status)
        ST_ENTRY: begin
          out_task_r     <= rd_id;
          out_priority_r <= OUT_PRIO_W'(rd_prio);
          out_rank_r     <= RANK_W'(idx_r);
          out_last_r     <= stat.list_last;
        end
        ST_EMPTY: begin
          out_task_r     <= '0;
          out_priority_r <= '0;
          out_rank_r     <= '0;
          out_last_r     <= 1'b1;
        end
        ST_ABSENT: begin
          out_task_r     <= id_r;
          out_priority_r <= '0;
          out_rank_r     <= '0;
          out_last_r     <= 1'b1;
        end
        default: begin
          out_task_r     <= id_r;
          out_priority_r <= '0;
          out_rank_r     <= RANK_W'(idx_r);
          out_last_r     <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_task     = out_task_r;
  assign out_priority = out_priority_r;
  assign out_rank     = out_rank_r;
  assign out_last     = out_last_r;

endmodule

// File: hdl/priority_ready_list.sv
// priority ready list top level: sequencer plus sorted task store
//
//   channel   ports                                             handshake
//   input     in_operation, in_task_id, in_priority_req         start && !busy
//   result    out_status, out_task, out_priority, out_rank,     out_valid strobe
//             out_last
//
// a transaction is latched in the idle state and decided in the decide state;
// insert and remove then scan the store from the head, one entry per cycle,
// and list emits one result per entry, one per cycle. synchronous active-low
// reset empties the list at once, no clearing pass. results cannot be
// stalled; busy stays high until the last result is shown.
module priority_ready_list import prl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [ID_W-1:0]       in_task_id,
  input  logic [IN_PRIO_W-1:0]  in_priority_req,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ID_W-1:0]       out_task,
  output logic [OUT_PRIO_W-1:0] out_priority,
  output logic [RANK_W-1:0]     out_rank,
  output logic                  out_last
);

  prl_cmd_t  cmd;
  prl_stat_t stat;

  prl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  prl_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_operation),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_task        (out_task),
    .out_priority    (out_priority),
    .out_rank        (out_rank),
    .out_last        (out_last)
  );

`ifndef SYNTHESIS
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("final result shown while still busy");

  a_more_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("sequencer idle in the middle of a list");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_insert |-> !stat.full && !stat.present)
    else $error("insert into full store or of a listed task");
`endif

endmodule

// File: test/tb_priority_ready_list.sv
// testbench for the priority ready list: directed table, then random traffic checked by a predictor
module tb_priority_ready_list import prl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 200;

  typedef struct packed {
    status_t               status;
    logic [ID_W-1:0]       task_id;
    logic [OUT_PRIO_W-1:0] prio;
    logic [RANK_W-1:0]     rank;
    logic                  last;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [ID_W-1:0]      id;
    logic [IN_PRIO_W-1:0] prio;
    logic                 typed;
    status_t              status;
    logic [RANK_W-1:0]    rank;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [OP_W-1:0]       in_operation;
  logic [ID_W-1:0]       in_task_id;
  logic [IN_PRIO_W-1:0]  in_priority_req;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [ID_W-1:0]       out_task;
  logic [OUT_PRIO_W-1:0] out_priority;
  logic [RANK_W-1:0]     out_rank;
  logic                  out_last;

  logic [ID_W-1:0]      sorted_ids [MAX_TASKS];
  logic [PRIO_BITS-1:0] sorted_prios [MAX_TASKS];
  int                   listed_count = 0;
  logic [ID_COUNT-1:0]  listed_mask = '0;
  list_result_t         pending_results [$];
  stim_row_t            directed_rows [$];
  int                   error_count = 0;

  priority_ready_list u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_task        (out_task),
    .out_priority    (out_priority),
    .out_rank        (out_rank),
    .out_last        (out_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int find_rank(logic [ID_W-1:0] id);
    for (int i = 0; i < listed_count; i++) begin
      if (sorted_ids[i] == id) return i;
    end
    return 0;
  endfunction

  task automatic push_result(status_t st, logic [ID_W-1:0] id, logic [OUT_PRIO_W-1:0] pr,
                             int rank, logic last);
    list_result_t r;
    r.status  = st;
    r.task_id = id;
    r.prio    = pr;
    r.rank    = rank[RANK_W-1:0];
    r.last    = last;
    pending_results.push_back(r);
  endtask

  task automatic predict_ready_list(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                    logic [IN_PRIO_W-1:0] prio_in);
    int pos;
    logic [PRIO_BITS-1:0] prio;
    prio = prio_in[PRIO_BITS-1:0];
    case (op)
      OP_INSERT: begin
        if (listed_mask[id]) begin
          push_result(ST_PRESENT, id, '0, find_rank(id), 1'b1);
        end else if (listed_count >= MAX_TASKS) begin
          push_result(ST_ABSENT, id, '0, 0, 1'b1);
        end else begin
          pos = listed_count;
          while (pos > 0 && sorted_prios[pos-1] < prio) pos--;
          for (int i = listed_count; i > pos; i--) begin
            sorted_ids[i]   = sorted_ids[i-1];
            sorted_prios[i] = sorted_prios[i-1];
          end
          sorted_ids[pos]   = id;
          sorted_prios[pos] = prio;
          listed_count++;
          listed_mask[id] = 1'b1;
          push_result(ST_INSERTED, id, '0, pos, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (!listed_mask[id]) begin
          push_result(ST_ABSENT, id, '0, 0, 1'b1);
        end else begin
          pos = find_rank(id);
          for (int i = pos; i + 1 < listed_count; i++) begin
            sorted_ids[i]   = sorted_ids[i+1];
            sorted_prios[i] = sorted_prios[i+1];
          end
          listed_count--;
          listed_mask[id] = 1'b0;
          push_result(ST_REMOVED, id, '0, pos, 1'b1);
        end
      end
      OP_LIST: begin
        if (listed_count == 0) begin
          push_result(ST_EMPTY, '0, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < listed_count; i++) begin
            push_result(ST_ENTRY, sorted_ids[i], OUT_PRIO_W'(sorted_prios[i]), i,
                        i + 1 == listed_count);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, logic [7:0] expv, logic [7:0] act);
    if (act !== expv) begin
      $error("%s expected %0d got %0d", name, expv, act);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result status %0d task %0d", out_status, out_task);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_status", 8'(want.status), 8'(out_status));
        check_field("out_task", 8'(want.task_id), 8'(out_task));
        check_field("out_priority", 8'(want.prio), 8'(out_priority));
        check_field("out_rank", 8'(want.rank), 8'(out_rank));
        check_field("out_last", 8'(want.last), 8'(out_last));
      end
    end
  end

  task automatic add_row(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [IN_PRIO_W-1:0] prio,
                         logic typed, status_t st, logic [RANK_W-1:0] rank);
    stim_row_t row;
    row.op     = op;
    row.id     = id;
    row.prio   = prio;
    row.typed  = typed;
    row.status = st;
    row.rank   = rank;
    directed_rows.push_back(row);
  endtask

  // offer one transaction and hold it until accepted; start is left high
  task automatic issue(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [IN_PRIO_W-1:0] prio);
    start           <= 1'b1;
    in_operation    <= op;
    in_task_id      <= id;
    in_priority_req <= prio;
    do @(posedge clk); while (busy);
    predict_ready_list(op, id, prio);
  endtask

  // sender gap with junk on the fields
  task automatic hold_off(int cycles);
    repeat (cycles) begin
      start           <= 1'b0;
      in_operation    <= OP_W'($urandom);
      in_task_id      <= ID_W'($urandom);
      in_priority_req <= IN_PRIO_W'($urandom);
      @(posedge clk);
    end
  endtask

  initial begin : drive
    int n;
    int burst;
    int pick;
    int ins_weight;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    logic [IN_PRIO_W-1:0] prio;
    list_result_t typed_res;

    start           <= 1'b0;
    in_operation    <= '0;
    in_task_id      <= '0;
    in_priority_req <= '0;
    rst_n           <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(OP_LIST,   4'd0,  8'd0,   1'b1, ST_EMPTY,    4'd0);
    add_row(OP_REMOVE, 4'd5,  8'd0,   1'b1, ST_ABSENT,   4'd0);
    add_row(OP_INSERT, 4'd0,  8'd0,   1'b1, ST_INSERTED, 4'd0);
    add_row(OP_INSERT, 4'd15, 8'hff,  1'b1, ST_INSERTED, 4'd0);
    add_row(OP_INSERT, 4'd0,  8'd7,   1'b1, ST_PRESENT,  4'd1);
    add_row(OP_INSERT, 4'd7,  8'hff,  1'b1, ST_INSERTED, 4'd1);
    add_row(OP_UNUSED, 4'd9,  8'haa,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_LIST,   4'd3,  8'h55,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_REMOVE, 4'd15, 8'd0,   1'b1, ST_REMOVED,  4'd0);
    add_row(OP_REMOVE, 4'd15, 8'd0,   1'b1, ST_ABSENT,   4'd0);
    add_row(OP_INSERT, 4'd1,  8'h80,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd2,  8'h01,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd3,  8'h80,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd4,  8'hff,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd5,  8'h00,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd6,  8'h55,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd8,  8'haa,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd9,  8'h80,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd10, 8'h01,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd11, 8'hfe,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd12, 8'h7f,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd13, 8'h00,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd14, 8'hff,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd15, 8'h33,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_INSERT, 4'd3,  8'hff,  1'b0, ST_EMPTY,    4'd0);
    add_row(OP_LIST,   4'd0,  8'd0,   1'b0, ST_EMPTY,    4'd0);
    add_row(OP_REMOVE, 4'd9,  8'd0,   1'b0, ST_EMPTY,    4'd0);

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].op, directed_rows[i].id, directed_rows[i].prio);
      if (directed_rows[i].typed) begin
        void'(pending_results.pop_back());
        typed_res.status  = directed_rows[i].status;
        typed_res.task_id = (directed_rows[i].status == ST_EMPTY) ? '0 : directed_rows[i].id;
        typed_res.prio    = '0;
        typed_res.rank    = directed_rows[i].rank;
        typed_res.last    = 1'b1;
        pending_results.push_back(typed_res);
      end
      hold_off($urandom_range(0, 3));
    end

    // alternate insert-heavy and remove-heavy stretches so the list fills and drains
    n = 0;
    burst = $urandom_range(1, 12);
    while (n < RANDOM_ITEMS) begin
      ins_weight = ((n / 40) % 2 == 0) ? 60 : 30;
      pick = $urandom_range(0, 99);
      if (pick < 4) op = OP_UNUSED;
      else if (pick < 4 + ins_weight) op = OP_INSERT;
      else if (pick < 86) op = OP_REMOVE;
      else op = OP_LIST;
      id = ID_W'($urandom_range(0, ID_COUNT - 1));
      if (op == OP_REMOVE && listed_mask != '0 && $urandom_range(0, 3) != 0) begin
        while (!listed_mask[id]) id = ID_W'($urandom_range(0, ID_COUNT - 1));
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0: prio = 8'h00;
          1: prio = 8'h40;
          2: prio = 8'h80;
          default: prio = 8'hff;
        endcase
      end else begin
        prio = IN_PRIO_W'($urandom_range(0, 255));
      end
      issue(op, id, prio);
      if (op != OP_UNUSED) n++;
      burst--;
      if (burst == 0) begin
        hold_off($urandom_range(1, 20));
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      end
    end
    hold_off(1);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_priority_ready_list: clean");
    end else begin
      $display("tb_priority_ready_list: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("tb_priority_ready_list: errors");
    $finish;
  end

endmodule
